### hw/rtl/ilte_pkg.sv
// shared types and constants of the indexed list table engine
`timescale 1ns / 1ps

package ilte_pkg;

  localparam int DEPTH_DEF   = 32;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 6;
  localparam int ACT_W       = 4;
  localparam int ST_W        = 2;
  localparam int CNT_OUT_W   = 6;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND     = 4'd0,
    ACT_PUSH_FRONT = 4'd1,
    ACT_INSERT     = 4'd2,
    ACT_REMOVE     = 4'd3,
    ACT_SET        = 4'd4,
    ACT_GET        = 4'd5,
    ACT_FRONT      = 4'd6,
    ACT_BACK       = 4'd7,
    ACT_FIND       = 4'd8,
    ACT_ROT_RIGHT  = 4'd9,
    ACT_ROT_LEFT   = 4'd10
  } act_t;

  typedef enum logic [ST_W-1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_FULL  = 2'd2,
    STS_MISS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ctrl_state_t;

  // command broadcast to every cell
  typedef struct packed {
    logic shr;       // take left neighbor above the shift point
    logic shl;       // take right neighbor from the shift point up
    logic wr;        // write the word at the write index
    logic load;      // load the probe chain from the entries
    logic by_index;  // probe marks the index instead of a matching value
  } cell_ctl_t;

endpackage

### hw/rtl/indexed_list_table_engine.sv
// top level: ordered list of signed words held in a row of shifting cells
`timescale 1ns / 1ps
//
// Ordered list of up to DEPTH signed 32-bit words with push, insert, remove,
// set, get, front, back, find and rotate actions.
// Input channel in_*: one action per transfer; output channel out_*: exactly
// one result transfer per action, in order.
// Each cell holds one entry and shifts together with its neighbors, so append,
// push, insert, set, front and rotate left finish without a scan. Get, remove,
// back, find and rotate right (unless refused or on an empty list) walk a probe
// copy of the list down the cell row to the head, one entry a cycle, up to the
// index read or found (the last entry for a find that misses). A new input
// transfer is taken only after the last action has finished; it does not wait
// for the result to be taken while the output register is free.
// Reset clears the entry count and the output valid; entry contents are not
// cleared. While out_tready stays low the result is held in the output
// register and a finished action waits for it to drain.
//
module indexed_list_table_engine #(
  parameter int DEPTH = ilte_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // action[3:0], position[9:4], word[41:10], zero fill
  input  logic [ilte_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // read_word[31:0], found_position[37:32], status[39:38], entry_count[45:40]
  output logic [ilte_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ilte_pkg::cell_ctl_t         ctl;
  logic [IW-1:0]               at, wat, midx;
  logic [ilte_pkg::DATA_W-1:0] cell_word;
  logic [CW-1:0]               count;

  logic [ilte_pkg::DATA_W-1:0] c_data [DEPTH];
  logic [ilte_pkg::DATA_W-1:0] c_pd   [DEPTH];
  logic                        c_pm   [DEPTH];

  ilte_ctrl #(
    .DEPTH(DEPTH),
    .IW   (IW),
    .CW   (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .ctl       (ctl),
    .at        (at),
    .wat       (wat),
    .midx      (midx),
    .cell_word (cell_word),
    .count     (count),
    .head_data (c_data[0]),
    .probe_d   (c_pd[0]),
    .probe_m   (c_pm[0])
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ilte_pkg::DATA_W-1:0] prev_d, next_d, next_p;
    logic                        next_m;

    if (i == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_mid
      assign prev_d = c_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_d = '0;
      assign next_p = '0;
      assign next_m = 1'b0;
    end else begin : g_inner
      assign next_d = c_data[i+1];
      assign next_p = c_pd[i+1];
      assign next_m = c_pm[i+1];
    end

    ilte_cell #(
      .IW (IW),
      .CW (CW),
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .at       (at),
      .wat      (wat),
      .midx     (midx),
      .cell_word(cell_word),
      .count    (count),
      .prev_data(prev_d),
      .next_data(next_d),
      .next_pd  (next_p),
      .next_pm  (next_m),
      .data     (c_data[i]),
      .pd       (c_pd[i]),
      .pm       (c_pm[i])
    );
  end

endmodule

### hw/rtl/ilte_cell.sv
// one list entry with its shift path and probe stage
`timescale 1ns / 1ps

module ilte_cell #(
  parameter int IW  = 5,
  parameter int CW  = 6,
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  ilte_pkg::cell_ctl_t          ctl,
  input  logic [IW-1:0]                at,
  input  logic [IW-1:0]                wat,
  input  logic [IW-1:0]                midx,
  input  logic [ilte_pkg::DATA_W-1:0]  cell_word,
  input  logic [CW-1:0]                count,
  input  logic [ilte_pkg::DATA_W-1:0]  prev_data,
  input  logic [ilte_pkg::DATA_W-1:0]  next_data,
  input  logic [ilte_pkg::DATA_W-1:0]  next_pd,
  input  logic                         next_pm,
  output logic [ilte_pkg::DATA_W-1:0]  data,
  output logic [ilte_pkg::DATA_W-1:0]  pd,
  output logic                         pm
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_CNT = CW'(IDX);

  logic [ilte_pkg::DATA_W-1:0] data_r, data_nxt;
  logic [ilte_pkg::DATA_W-1:0] pd_r, pd_nxt;
  logic                        pm_r, pm_nxt;

  always_comb begin
    priority if (ctl.wr && (wat == MY_IDX)) begin
      data_nxt = cell_word;
    end else if (ctl.shr && (MY_IDX > at)) begin
      data_nxt = prev_data;
    end else if (ctl.shl && (MY_IDX >= at)) begin
      data_nxt = next_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_comb begin
    if (ctl.load) begin
      pd_nxt = data_r;
      pm_nxt = ctl.by_index ? (midx == MY_IDX)
                            : ((data_r == cell_word) && (MY_CNT < count));
    end else begin
      pd_nxt = next_pd;
      pm_nxt = next_pm;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    pd_r   <= pd_nxt;
    pm_r   <= pm_nxt;
  end

  assign data = data_r;
  assign pd   = pd_r;
  assign pm   = pm_r;

endmodule

### hw/rtl/ilte_ctrl.sv
// sequencer: decodes actions, drives the cell row, scans the probe chain
`timescale 1ns / 1ps

module ilte_ctrl #(
  parameter int DEPTH = ilte_pkg::DEPTH_DEF,
  parameter int IW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ilte_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ilte_pkg::OUT_TDATA_W-1:0] out_tdata,
  output ilte_pkg::cell_ctl_t              ctl,
  output logic [IW-1:0]                    at,
  output logic [IW-1:0]                    wat,
  output logic [IW-1:0]                    midx,
  output logic [ilte_pkg::DATA_W-1:0]      cell_word,
  output logic [CW-1:0]                    count,
  input  logic [ilte_pkg::DATA_W-1:0]      head_data,
  input  logic [ilte_pkg::DATA_W-1:0]      probe_d,
  input  logic                             probe_m
);

  localparam int CMPW = (CW > ilte_pkg::POS_W) ? CW : ilte_pkg::POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam int OUT_PAD = ilte_pkg::OUT_TDATA_W - ilte_pkg::DATA_W - ilte_pkg::POS_W
                           - ilte_pkg::ST_W - ilte_pkg::CNT_OUT_W;

  ilte_pkg::ctrl_state_t state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         k_r, k_nxt;
  logic [IW-1:0]         lim_r, lim_nxt;
  ilte_pkg::act_t        act_r, act_nxt;
  logic [ilte_pkg::DATA_W-1:0] res_rd_r, res_rd_nxt;
  logic [ilte_pkg::POS_W-1:0]  res_fp_r, res_fp_nxt;
  ilte_pkg::status_t     res_st_r, res_st_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ilte_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  ilte_pkg::act_t              in_act;
  logic [ilte_pkg::POS_W-1:0]  in_pos;
  logic [ilte_pkg::DATA_W-1:0] in_word;
  logic [CMPW-1:0]             pos_x, cnt_x;
  logic [CW-1:0]               cnt_m1;
  logic                        full, empty, slot_free;

  assign in_act  = ilte_pkg::act_t'(in_tdata[ilte_pkg::ACT_W-1:0]);
  assign in_pos  = in_tdata[ilte_pkg::ACT_W +: ilte_pkg::POS_W];
  assign in_word = in_tdata[ilte_pkg::ACT_W + ilte_pkg::POS_W +: ilte_pkg::DATA_W];
  assign pos_x   = CMPW'(in_pos);
  assign cnt_x   = CMPW'(count_r);
  assign cnt_m1  = count_r - CW'(1);
  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    lim_nxt    = lim_r;
    act_nxt    = act_r;
    res_rd_nxt = res_rd_r;
    res_fp_nxt = res_fp_r;
    res_st_nxt = res_st_r;
    ctl        = '0;
    at         = '0;
    wat        = '0;
    midx       = '0;
    cell_word  = in_word;
    in_tready  = 1'b0;

    unique case (state_r)
      ilte_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          act_nxt    = in_act;
          res_rd_nxt = '0;
          res_fp_nxt = '0;
          res_st_nxt = ilte_pkg::STS_OK;
          k_nxt      = '0;
          lim_nxt    = IW'(cnt_m1);
          state_nxt  = ilte_pkg::ST_DONE;
          unique case (in_act)
            ilte_pkg::ACT_APPEND: begin
              if (full) begin
                res_st_nxt = ilte_pkg::STS_FULL;
              end else begin
                ctl.wr    = 1'b1;
                wat       = IW'(count_r);
                count_nxt = count_r + CW'(1);
              end
            end
            ilte_pkg::ACT_PUSH_FRONT: begin
              if (full) begin
                res_st_nxt = ilte_pkg::STS_FULL;
              end else begin
                ctl.shr   = 1'b1;
                ctl.wr    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            ilte_pkg::ACT_INSERT: begin
              if (pos_x > cnt_x) begin
                res_st_nxt = ilte_pkg::STS_RANGE;
              end else if (full) begin
                res_st_nxt = ilte_pkg::STS_FULL;
              end else begin
                ctl.shr   = 1'b1;
                ctl.wr    = 1'b1;
                at        = IW'(in_pos);
                wat       = IW'(in_pos);
                count_nxt = count_r + CW'(1);
              end
            end
            ilte_pkg::ACT_REMOVE: begin
              if (pos_x >= cnt_x) begin
                res_st_nxt = ilte_pkg::STS_RANGE;
              end else begin
                ctl.shl      = 1'b1;
                at           = IW'(in_pos);
                ctl.load     = 1'b1;
                ctl.by_index = 1'b1;
                midx         = IW'(in_pos);
                count_nxt    = cnt_m1;
                state_nxt    = ilte_pkg::ST_SCAN;
              end
            end
            ilte_pkg::ACT_SET: begin
              if (pos_x >= cnt_x) begin
                res_st_nxt = ilte_pkg::STS_RANGE;
              end else begin
                ctl.wr = 1'b1;
                wat    = IW'(in_pos);
              end
            end
            ilte_pkg::ACT_GET: begin
              if (pos_x >= cnt_x) begin
                res_st_nxt = ilte_pkg::STS_RANGE;
              end else begin
                ctl.load     = 1'b1;
                ctl.by_index = 1'b1;
                midx         = IW'(in_pos);
                state_nxt    = ilte_pkg::ST_SCAN;
              end
            end
            ilte_pkg::ACT_FRONT: begin
              if (empty) begin
                res_st_nxt = ilte_pkg::STS_RANGE;
              end else begin
                res_rd_nxt = head_data;
              end
            end
            ilte_pkg::ACT_BACK, ilte_pkg::ACT_ROT_RIGHT: begin
              if (empty) begin
                if (in_act == ilte_pkg::ACT_BACK) begin
                  res_st_nxt = ilte_pkg::STS_RANGE;
                end
              end else begin
                ctl.load     = 1'b1;
                ctl.by_index = 1'b1;
                midx         = IW'(cnt_m1);
                state_nxt    = ilte_pkg::ST_SCAN;
              end
            end
            ilte_pkg::ACT_FIND: begin
              if (empty) begin
                res_st_nxt = ilte_pkg::STS_MISS;
              end else begin
                ctl.load  = 1'b1;
                state_nxt = ilte_pkg::ST_SCAN;
              end
            end
            ilte_pkg::ACT_ROT_LEFT: begin
              if (!empty) begin
                ctl.shl   = 1'b1;
                ctl.wr    = 1'b1;
                wat       = IW'(cnt_m1);
                cell_word = head_data;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ilte_pkg::ST_SCAN: begin
        // probe head shows entry k_r
        if (probe_m) begin
          res_st_nxt = ilte_pkg::STS_OK;
          if (act_r == ilte_pkg::ACT_GET || act_r == ilte_pkg::ACT_REMOVE ||
              act_r == ilte_pkg::ACT_BACK) begin
            res_rd_nxt = probe_d;
          end
          if (act_r == ilte_pkg::ACT_FIND) begin
            res_fp_nxt = ilte_pkg::POS_W'(k_r);
          end
          if (act_r == ilte_pkg::ACT_ROT_RIGHT) begin
            ctl.shr   = 1'b1;
            ctl.wr    = 1'b1;
            cell_word = probe_d;
          end
          state_nxt = ilte_pkg::ST_DONE;
        end else if (k_r == lim_r) begin
          res_st_nxt = ilte_pkg::STS_MISS;
          state_nxt  = ilte_pkg::ST_DONE;
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end

      ilte_pkg::ST_DONE: begin
        if (slot_free) begin
          state_nxt = ilte_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ilte_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (state_r == ilte_pkg::ST_DONE && slot_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {{OUT_PAD{1'b0}}, ilte_pkg::CNT_OUT_W'(count_r), res_st_r,
                       res_fp_r, res_rd_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ilte_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    lim_r      <= lim_nxt;
    act_r      <= act_nxt;
    res_rd_r   <= res_rd_nxt;
    res_fp_r   <= res_fp_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign count      = count_r;

endmodule
